### hdl/pdta_pkg.sv
package pdta_pkg;

    // field widths
    localparam int unsigned TimeW   = 32;
    localparam int unsigned SampleW = 10;
    localparam int unsigned CountW  = 16;
    localparam int unsigned DelayW  = 20;
    localparam int unsigned PowerW  = 8;
    localparam int unsigned BucketW = 26;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 20;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_VALID_LOW     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_VALID_HIGH    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PULSE_THRESH  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RECAL_MS      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MIN_INTERVAL  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BUZZER_DELAY  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_BUZZER_POWER  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_NO_BEAT_LIMIT = 3'd7;

    // timing constants
    localparam logic [TimeW-1:0]  CALIB_MS      = 32'd500;
    localparam logic [CountW-1:0] COUNT_MAX     = 16'hFFFF;

    // now / 100 == (now >> 2) * ceil(2^35 / 25) >> 35, exact for 30-bit operands
    localparam logic [30:0] BUCKET_RECIP = 31'd1374389535;
    localparam int unsigned BUCKET_SHIFT = 35;
    // x / 1000 == (x >> 3) * ceil(2^36 / 125) >> 36, exact for 29-bit operands
    localparam logic [29:0] SECOND_RECIP = 30'd549755814;
    localparam int unsigned SECOND_SHIFT = 36;
    // count / 10 == count * ceil(2^19 / 10) >> 19, exact for 16-bit operands
    localparam logic [15:0] TENTH_RECIP  = 16'd52429;
    localparam int unsigned TENTH_SHIFT  = 19;

    typedef struct packed {
        logic [SampleW-1:0] valid_low;
        logic [SampleW-1:0] valid_high;
        logic [SampleW-1:0] pulse_threshold;
        logic [CountW-1:0]  recal_interval_ms;
        logic [CountW-1:0]  min_interval_ms;
        logic [DelayW-1:0]  buzzer_delay_ms;
        logic [PowerW-1:0]  buzzer_power;
        logic [CountW-1:0]  no_beat_limit_s;
    } cfg_t;

endpackage

### hdl/pulse_detector_with_timeout_alarm_unit.sv
// Pulse detector with no-beat alarm: takes one item per clock while the pipeline advances
// and returns one result per item (input register, bucket-index multiply, state update,
// then buzzer and alarm multiply into the result register). All stages advance together; a
// stalled result register holds the whole pipeline, so s_ready follows m_ready whenever a
// result is waiting. The detector state updates in a single stage, which is what lets
// consecutive items follow each other every cycle. Configuration writes take effect on the
// next clock and are meant to be done while no items are in flight.
module pulse_detector_with_timeout_alarm_unit import pdta_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TimeW-1:0]    s_time_ms,
    input  logic [SampleW-1:0]  s_sample,
    input  logic                s_motion_status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_pulse,
    output logic                m_motion,
    output logic [PowerW-1:0]   m_buzzer_level,
    output logic [CountW-1:0]   m_no_beat_buckets,
    output logic                m_no_beat_alarm,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cfg_t cfg;
    logic advance;

    pdta_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage registers
    logic               v0_reg, v1_reg, v2_reg, m_valid_reg;
    logic [TimeW-1:0]   t0_reg, t1_reg;
    logic [SampleW-1:0] smp0_reg, smp1_reg;
    logic               mot0_reg, mot1_reg;
    logic [BucketW-1:0] bucket1_reg;
    logic               pulse2_reg, motion2_reg;
    logic [CountW-1:0]  count2_reg;
    logic [TimeW-1:0]   since2_reg;
    logic               m_pulse_reg, m_motion_reg, m_alarm_reg;
    logic [PowerW-1:0]  m_level_reg;
    logic [CountW-1:0]  m_count_reg;

    // detector state
    logic [TimeW-1:0]   last_detect_reg, last_detect_next;
    logic [TimeW-1:0]   calib_start_reg, calib_start_next;
    logic               stable_reg, stable_next;
    logic               pulse_reg, pulse_next;
    logic               first_reg, first_next;
    logic [BucketW-1:0] prev_bucket_reg, prev_bucket_next;
    logic               beat_seen_reg, beat_seen_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic [TimeW-1:0]   last_beat_reg, last_beat_next;
    logic               motion_next;
    logic [TimeW-1:0]   since_next;

    // whole pipeline moves when the result register is empty or being taken
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // stage 0: input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_valid;
        end
        if (advance && s_valid) begin
            t0_reg   <= s_time_ms;
            smp0_reg <= s_sample;
            mot0_reg <= s_motion_status;
        end
    end

    // bucket index: now / 100 through a reciprocal multiply
    logic [60:0]        bucket_prod;
    logic [BucketW-1:0] bucket0;
    assign bucket_prod = 61'(t0_reg[TimeW-1:2]) * 61'(BUCKET_RECIP);
    assign bucket0     = bucket_prod[BUCKET_SHIFT +: BucketW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= v0_reg;
        end
        if (advance && v0_reg) begin
            t1_reg      <= t0_reg;
            smp1_reg    <= smp0_reg;
            mot1_reg    <= mot0_reg;
            bucket1_reg <= bucket0;
        end
    end

    // stage 1: detector and bucket state update
    logic [TimeW-1:0] since_detect, since_calib;
    logic             smp_valid, beat_tmp;

    always_comb begin
        since_detect     = t1_reg - last_detect_reg;
        since_calib      = t1_reg - calib_start_reg;
        smp_valid        = (smp1_reg > cfg.valid_low) && (smp1_reg < cfg.valid_high);
        last_detect_next = last_detect_reg;
        calib_start_next = calib_start_reg;
        stable_next      = stable_reg;
        pulse_next       = pulse_reg;
        first_next       = first_reg;

        // pulse detection
        if (!smp_valid) begin
            pulse_next = 1'b0;
        end else if (since_detect > 32'(cfg.recal_interval_ms) || first_reg) begin
            calib_start_next = t1_reg;
            last_detect_next = t1_reg;
            stable_next      = 1'b0;
            first_next       = 1'b0;
        end else if (since_calib > CALIB_MS) begin
            if (!stable_reg) begin
                stable_next = 1'b1;
            end else if (since_detect > 32'(cfg.min_interval_ms)
                         && smp1_reg > cfg.pulse_threshold) begin
                last_detect_next = t1_reg;
                pulse_next       = 1'b1;
            end else begin
                pulse_next = 1'b0;
            end
        end

        // no-beat bucket counting
        beat_tmp         = beat_seen_reg || pulse_next;
        prev_bucket_next = prev_bucket_reg;
        beat_seen_next   = beat_tmp;
        count_next       = count_reg;
        motion_next      = 1'b0;
        if (bucket1_reg != prev_bucket_reg) begin
            prev_bucket_next = bucket1_reg;
            motion_next      = mot1_reg;
            if (beat_tmp) begin
                count_next     = '0;
                beat_seen_next = 1'b0;
            end else if (count_reg != COUNT_MAX) begin
                count_next = count_reg + 16'd1;
            end
        end

        // time since the last beat
        last_beat_next = pulse_next ? t1_reg : last_beat_reg;
        since_next     = t1_reg - last_beat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_detect_reg <= '0;
            calib_start_reg <= '0;
            stable_reg      <= 1'b0;
            pulse_reg       <= 1'b0;
            first_reg       <= 1'b1;
            prev_bucket_reg <= '0;
            beat_seen_reg   <= 1'b0;
            count_reg       <= '0;
            last_beat_reg   <= '0;
            v2_reg          <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
            if (v1_reg) begin
                last_detect_reg <= last_detect_next;
                calib_start_reg <= calib_start_next;
                stable_reg      <= stable_next;
                pulse_reg       <= pulse_next;
                first_reg       <= first_next;
                prev_bucket_reg <= prev_bucket_next;
                beat_seen_reg   <= beat_seen_next;
                count_reg       <= count_next;
                last_beat_reg   <= last_beat_next;
            end
        end
        if (advance && v1_reg) begin
            pulse2_reg  <= pulse_next;
            motion2_reg <= motion_next;
            count2_reg  <= count_next;
            since2_reg  <= since_next;
        end
    end

    // stage 2: blink phase (whole seconds odd) and alarm compare
    logic [58:0]       sec_prod;
    logic [31:0]       tenth_prod;
    logic              blink_on, buzz_on, alarm;
    logic [PowerW-1:0] level;

    assign sec_prod   = 59'(since2_reg[TimeW-1:3]) * 59'(SECOND_RECIP);
    assign blink_on   = sec_prod[SECOND_SHIFT];
    assign buzz_on    = (since2_reg > 32'(cfg.buzzer_delay_ms)) && blink_on;
    assign level      = buzz_on ? cfg.buzzer_power : '0;
    assign tenth_prod = 32'(count2_reg) * 32'(TENTH_RECIP);
    assign alarm      = 16'(tenth_prod[TENTH_SHIFT +: (32 - TENTH_SHIFT)]) > cfg.no_beat_limit_s;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= v2_reg;
        end
        if (advance && v2_reg) begin
            m_pulse_reg  <= pulse2_reg;
            m_motion_reg <= motion2_reg;
            m_level_reg  <= level;
            m_count_reg  <= count2_reg;
            m_alarm_reg  <= alarm;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pulse           = m_pulse_reg;
    assign m_motion          = m_motion_reg;
    assign m_buzzer_level    = m_level_reg;
    assign m_no_beat_buckets = m_count_reg;
    assign m_no_beat_alarm   = m_alarm_reg;

endmodule

### hdl/pdta_cfg.sv
module pdta_cfg import pdta_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    // register file with reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.valid_low         <= 10'd100;
            cfg_reg.valid_high        <= 10'd1000;
            cfg_reg.pulse_threshold   <= 10'd550;
            cfg_reg.recal_interval_ms <= 16'd3000;
            cfg_reg.min_interval_ms   <= 16'd300;
            cfg_reg.buzzer_delay_ms   <= 20'd10000;
            cfg_reg.buzzer_power      <= 8'd255;
            cfg_reg.no_beat_limit_s   <= 16'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_VALID_LOW:     cfg_reg.valid_low         <= cfg_data[SampleW-1:0];
                CFG_VALID_HIGH:    cfg_reg.valid_high        <= cfg_data[SampleW-1:0];
                CFG_PULSE_THRESH:  cfg_reg.pulse_threshold   <= cfg_data[SampleW-1:0];
                CFG_RECAL_MS:      cfg_reg.recal_interval_ms <= cfg_data[CountW-1:0];
                CFG_MIN_INTERVAL:  cfg_reg.min_interval_ms   <= cfg_data[CountW-1:0];
                CFG_BUZZER_DELAY:  cfg_reg.buzzer_delay_ms   <= cfg_data[DelayW-1:0];
                CFG_BUZZER_POWER:  cfg_reg.buzzer_power      <= cfg_data[PowerW-1:0];
                CFG_NO_BEAT_LIMIT: cfg_reg.no_beat_limit_s   <= cfg_data[CountW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/pdta_checker.sv
module pdta_checker import pdta_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_pulse,
    input logic                m_motion,
    input logic [PowerW-1:0]   m_buzzer_level,
    input logic [CountW-1:0]   m_no_beat_buckets,
    input logic                m_no_beat_alarm
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a taken or empty result slot always frees the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while output can move");

    // alarm needs at least ten no-beat buckets
    a_alarm_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_beat_buckets < 16'd10) |-> !m_no_beat_alarm)
        else $error("alarm raised below ten buckets");

    // stalled result holds its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pulse) && $stable(m_motion)
            && $stable(m_buzzer_level) && $stable(m_no_beat_buckets)
            && $stable(m_no_beat_alarm)))
        else $error("stalled result changed");

endmodule

bind pulse_detector_with_timeout_alarm_unit pdta_checker u_pdta_checker (.*);

### bench/pdta_readout_checker.sv
module pdta_readout_checker import pdta_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [TimeW-1:0]    s_time_ms,
    input  logic [SampleW-1:0]  s_sample,
    input  logic                s_motion_status,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_pulse,
    input  logic                m_motion,
    input  logic [PowerW-1:0]   m_buzzer_level,
    input  logic [CountW-1:0]   m_no_beat_buckets,
    input  logic                m_no_beat_alarm,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  fail_count,
    output int                  readouts_in_flight
);

    localparam int unsigned CalibWindowMs = 500;
    localparam int unsigned BucketMs      = 100;
    localparam int unsigned SecondMs      = 1000;
    localparam int unsigned BucketsPerSec = 10;

    typedef struct packed {
        logic              pulse;
        logic              motion;
        logic [PowerW-1:0] buzzer_level;
        logic [CountW-1:0] no_beat_buckets;
        logic              no_beat_alarm;
    } readout_t;

    // shadow of the register file and the detector state
    cfg_t              model_cfg;
    logic [TimeW-1:0]  last_detect_ms;
    logic [TimeW-1:0]  calib_start_ms;
    logic              stable;
    logic              pulse_on;
    logic              first_sample;
    logic [BucketW-1:0] prev_bucket;
    logic              beat_in_bucket;
    logic [CountW-1:0] no_beat_count;
    logic [TimeW-1:0]  last_beat_ms;

    readout_t          expected_readouts[$];
    readout_t          want;

    // detector, bucket counter and buzzer for one accepted item
    task automatic predict_readout(input logic [TimeW-1:0] now,
                                   input logic [SampleW-1:0] smp,
                                   input logic mot,
                                   output readout_t r);
        logic [TimeW-1:0]   since_detect;
        logic [TimeW-1:0]   since_beat;
        logic [TimeW-1:0]   since_beat_s;
        logic [BucketW-1:0] bucket;
        since_detect = now - last_detect_ms;
        r = '0;

        // pulse detection
        if (!(smp > model_cfg.valid_low && smp < model_cfg.valid_high)) begin
            pulse_on = 1'b0;
        end else if (since_detect > model_cfg.recal_interval_ms || first_sample) begin
            calib_start_ms = now;
            last_detect_ms = now;
            stable = 1'b0;
            first_sample = 1'b0;
        end else if (TimeW'(now - calib_start_ms) > CalibWindowMs) begin
            if (!stable) begin
                stable = 1'b1;
            end else if (since_detect > model_cfg.min_interval_ms &&
                         smp > model_cfg.pulse_threshold) begin
                last_detect_ms = now;
                pulse_on = 1'b1;
            end else begin
                pulse_on = 1'b0;
            end
        end

        if (pulse_on) begin
            beat_in_bucket = 1'b1;
        end

        // 100 ms buckets, motion sampled once per bucket
        bucket = BucketW'(now / BucketMs);
        if (bucket != prev_bucket) begin
            prev_bucket = bucket;
            if (beat_in_bucket) begin
                no_beat_count = '0;
                beat_in_bucket = 1'b0;
            end else if (no_beat_count != COUNT_MAX) begin
                no_beat_count = no_beat_count + 1'b1;
            end
            r.motion = mot;
        end

        // buzzer blinks on odd seconds past the delay
        if (pulse_on) begin
            last_beat_ms = now;
        end
        since_beat = now - last_beat_ms;
        since_beat_s = since_beat / SecondMs;
        if (since_beat > model_cfg.buzzer_delay_ms && since_beat_s[0]) begin
            r.buzzer_level = model_cfg.buzzer_power;
        end

        r.pulse = pulse_on;
        r.no_beat_buckets = no_beat_count;
        r.no_beat_alarm = ((no_beat_count / BucketsPerSec) > model_cfg.no_beat_limit_s);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            model_cfg.valid_low <= 10'd100;
            model_cfg.valid_high <= 10'd1000;
            model_cfg.pulse_threshold <= 10'd550;
            model_cfg.recal_interval_ms <= 16'd3000;
            model_cfg.min_interval_ms <= 16'd300;
            model_cfg.buzzer_delay_ms <= 20'd10000;
            model_cfg.buzzer_power <= 8'd255;
            model_cfg.no_beat_limit_s <= 16'd10;
            last_detect_ms = '0;
            calib_start_ms = '0;
            stable = 1'b0;
            pulse_on = 1'b0;
            first_sample = 1'b1;
            prev_bucket = '0;
            beat_in_bucket = 1'b0;
            no_beat_count = '0;
            last_beat_ms = '0;
            expected_readouts.delete();
            fail_count = 0;
            readouts_in_flight = 0;
        end else begin
            // accepted sample: predict its readout
            if (s_valid && s_ready) begin
                predict_readout(s_time_ms, s_sample, s_motion_status, want);
                expected_readouts.push_back(want);
            end

            // accepted readout: compare against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_readouts.size() == 0) begin
                    $error("readout with no item pending: pulse %0d buckets %0d",
                           m_pulse, m_no_beat_buckets);
                    fail_count++;
                end else begin
                    want = expected_readouts.pop_front();
                    if (m_pulse !== want.pulse) begin
                        $error("pulse mismatch: expected %0d, actual %0d",
                               want.pulse, m_pulse);
                        fail_count++;
                    end
                    if (m_motion !== want.motion) begin
                        $error("motion mismatch: expected %0d, actual %0d",
                               want.motion, m_motion);
                        fail_count++;
                    end
                    if (m_buzzer_level !== want.buzzer_level) begin
                        $error("buzzer_level mismatch: expected %0d, actual %0d",
                               want.buzzer_level, m_buzzer_level);
                        fail_count++;
                    end
                    if (m_no_beat_buckets !== want.no_beat_buckets) begin
                        $error("no_beat_buckets mismatch: expected %0d, actual %0d",
                               want.no_beat_buckets, m_no_beat_buckets);
                        fail_count++;
                    end
                    if (m_no_beat_alarm !== want.no_beat_alarm) begin
                        $error("no_beat_alarm mismatch: expected %0d, actual %0d",
                               want.no_beat_alarm, m_no_beat_alarm);
                        fail_count++;
                    end
                end
            end

            // register writes take effect for the following items
            if (cfg_we) begin
                case (cfg_index)
                    CFG_VALID_LOW:     model_cfg.valid_low <= cfg_data[SampleW-1:0];
                    CFG_VALID_HIGH:    model_cfg.valid_high <= cfg_data[SampleW-1:0];
                    CFG_PULSE_THRESH:  model_cfg.pulse_threshold <= cfg_data[SampleW-1:0];
                    CFG_RECAL_MS:      model_cfg.recal_interval_ms <= cfg_data[CountW-1:0];
                    CFG_MIN_INTERVAL:  model_cfg.min_interval_ms <= cfg_data[CountW-1:0];
                    CFG_BUZZER_DELAY:  model_cfg.buzzer_delay_ms <= cfg_data[DelayW-1:0];
                    CFG_BUZZER_POWER:  model_cfg.buzzer_power <= cfg_data[PowerW-1:0];
                    CFG_NO_BEAT_LIMIT: model_cfg.no_beat_limit_s <= cfg_data[CountW-1:0];
                    default: ;
                endcase
            end

            readouts_in_flight = expected_readouts.size();
        end
    end

endmodule

### bench/pulse_detector_with_timeout_alarm_unit_tb.sv
module pulse_detector_with_timeout_alarm_unit_tb;
    import pdta_pkg::*;

    localparam int unsigned RandomPhases   = 8;
    localparam int unsigned ItemsPerPhase  = 155;
    localparam int unsigned DrainCycles    = 12;
    localparam int unsigned LongHoldCycles = 300;
    localparam logic [TimeW-1:0] DirBase   = 32'h0001_0000;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [TimeW-1:0]    s_time_ms = '0;
    logic [SampleW-1:0]  s_sample = '0;
    logic                s_motion_status = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_pulse;
    logic                m_motion;
    logic [PowerW-1:0]   m_buzzer_level;
    logic [CountW-1:0]   m_no_beat_buckets;
    logic                m_no_beat_alarm;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = CFG_VALID_LOW;
    logic [CfgDataW-1:0] cfg_data = '0;
    int                  fail_count;
    int                  readouts_in_flight;

    // traffic shaping shared between the sample and readout sides
    int                  tx_idle_pct = 0;
    int                  rx_stall_pct = 0;
    bit                  long_hold_req = 1'b0;

    // sample stream state
    cfg_t                cfg_shadow;
    logic [TimeW-1:0]    stim_time;
    logic [TimeW-1:0]    beat_anchor;
    int unsigned         beat_period;
    int                  flat_left;

    pulse_detector_with_timeout_alarm_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_ms         (s_time_ms),
        .s_sample          (s_sample),
        .s_motion_status   (s_motion_status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pulse           (m_pulse),
        .m_motion          (m_motion),
        .m_buzzer_level    (m_buzzer_level),
        .m_no_beat_buckets (m_no_beat_buckets),
        .m_no_beat_alarm   (m_no_beat_alarm),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    pdta_readout_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_time_ms          (s_time_ms),
        .s_sample           (s_sample),
        .s_motion_status    (s_motion_status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pulse            (m_pulse),
        .m_motion           (m_motion),
        .m_buzzer_level     (m_buzzer_level),
        .m_no_beat_buckets  (m_no_beat_buckets),
        .m_no_beat_alarm    (m_no_beat_alarm),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .readouts_in_flight (readouts_in_flight)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400000;
        $display("pulse_detector_with_timeout_alarm_unit_tb: FAIL");
        $finish;
    end

    // readout side: random stalls plus an occasional long hold-off
    initial begin : readout_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LongHoldCycles;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // offer one item, entered and left at a falling edge
    task automatic push_sample(input logic [TimeW-1:0] t, input logic [SampleW-1:0] smp,
                               input logic mot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_time_ms <= t;
        s_sample <= smp;
        s_motion_status <= mot;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // full register burst, enable held across consecutive cycles
    task automatic write_config(input cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_VALID_LOW;
        cfg_data <= CfgDataW'(c.valid_low);
        @(negedge aclk);
        cfg_index <= CFG_VALID_HIGH;
        cfg_data <= CfgDataW'(c.valid_high);
        @(negedge aclk);
        cfg_index <= CFG_PULSE_THRESH;
        cfg_data <= CfgDataW'(c.pulse_threshold);
        @(negedge aclk);
        cfg_index <= CFG_RECAL_MS;
        cfg_data <= CfgDataW'(c.recal_interval_ms);
        @(negedge aclk);
        cfg_index <= CFG_MIN_INTERVAL;
        cfg_data <= CfgDataW'(c.min_interval_ms);
        @(negedge aclk);
        cfg_index <= CFG_BUZZER_DELAY;
        cfg_data <= CfgDataW'(c.buzzer_delay_ms);
        @(negedge aclk);
        cfg_index <= CFG_BUZZER_POWER;
        cfg_data <= CfgDataW'(c.buzzer_power);
        @(negedge aclk);
        cfg_index <= CFG_NO_BEAT_LIMIT;
        cfg_data <= CfgDataW'(c.no_beat_limit_s);
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    // register setting per phase: defaults, extremes or random
    function automatic cfg_t phase_config(input int phase);
        cfg_t c;
        int lo;
        int hi;
        case (phase)
            0: begin
                c = '{valid_low: 10'd100, valid_high: 10'd1000, pulse_threshold: 10'd550,
                      recal_interval_ms: 16'd3000, min_interval_ms: 16'd300,
                      buzzer_delay_ms: 20'd10000, buzzer_power: 8'd255,
                      no_beat_limit_s: 16'd10};
            end
            1: begin
                // widest window, every valid sample can beat
                c = '{valid_low: 10'd0, valid_high: 10'd1023, pulse_threshold: 10'd0,
                      recal_interval_ms: 16'hFFFF, min_interval_ms: 16'd0,
                      buzzer_delay_ms: 20'd0, buzzer_power: 8'd255,
                      no_beat_limit_s: 16'd0};
            end
            3: begin
                c = '0;
            end
            4: begin
                c = '{valid_low: 10'd1023, valid_high: 10'd1023, pulse_threshold: 10'd1023,
                      recal_interval_ms: 16'hFFFF, min_interval_ms: 16'hFFFF,
                      buzzer_delay_ms: 20'd1000000, buzzer_power: 8'd255,
                      no_beat_limit_s: 16'hFFFF};
            end
            default: begin
                lo = $urandom_range(0, 400);
                hi = $urandom_range(600, 1023);
                c.valid_low = SampleW'(lo);
                c.valid_high = SampleW'(hi);
                c.pulse_threshold = SampleW'($urandom_range(hi, lo));
                c.recal_interval_ms = (phase == 6) ? CountW'($urandom_range(0, 200))
                                                   : CountW'($urandom_range(600, 8000));
                c.min_interval_ms = CountW'($urandom_range(0, 1500));
                c.buzzer_delay_ms = DelayW'($urandom_range(0, 30000));
                c.buzzer_power = PowerW'($urandom_range(0, 255));
                c.no_beat_limit_s = CountW'($urandom_range(0, 30));
            end
        endcase
        return c;
    endfunction

    // sensor level inside the valid window, above or below the threshold; any level if the window is empty
    function automatic logic [SampleW-1:0] pick_sample(input bit beat);
        int lo;
        int hi;
        int th;
        int a;
        int b;
        lo = int'(cfg_shadow.valid_low) + 1;
        hi = int'(cfg_shadow.valid_high) - 1;
        th = int'(cfg_shadow.pulse_threshold);
        if (lo > hi) begin
            return SampleW'($urandom_range(0, 1023));
        end
        a = beat ? ((th + 1 > lo) ? th + 1 : lo) : lo;
        b = beat ? hi : ((th < hi) ? th : hi);
        if (a > b) begin
            a = lo;
            b = hi;
        end
        return SampleW'($urandom_range(b, a));
    endfunction

    // next item of a heartbeat-like stream with flatlines, jumps and noise
    task automatic next_sample_item();
        int roll;
        bit beat;
        logic [SampleW-1:0] smp;
        logic [TimeW-1:0] since_anchor;
        roll = $urandom_range(0, 999);
        if (flat_left > 0) begin
            stim_time += $urandom_range(60, 180);
            flat_left--;
        end else if (roll < 5) begin
            stim_time -= $urandom_range(1, 5000);
        end else if (roll < 8) begin
            stim_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end else if (roll < 12) begin
            stim_time = $urandom();
        end else if (roll < 30) begin
            stim_time += $urandom_range(1000, 20000);
        end else if (roll < 33) begin
            flat_left = $urandom_range(80, 200);
            stim_time += $urandom_range(60, 180);
        end else begin
            stim_time += $urandom_range(0, 40);
        end

        since_anchor = stim_time - beat_anchor;
        if (since_anchor >= beat_period) begin
            beat_anchor = stim_time;
            beat_period = $urandom_range(350, 1100);
            since_anchor = '0;
        end
        beat = (flat_left == 0) && (since_anchor < 70);

        if ($urandom_range(0, 99) < 8) begin
            smp = SampleW'($urandom_range(0, 1023));
        end else begin
            smp = pick_sample(beat);
        end
        push_sample(stim_time, smp, 1'($urandom_range(0, 1)));
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int phase;
        int n;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed items under reset settings
        push_sample(DirBase, 10'd0, 1'b1);                      // invalid, new bucket
        push_sample(DirBase + 1, 10'd1023, 1'b1);               // invalid, same bucket
        push_sample(DirBase + 10, 10'd300, 1'b0);               // first valid, calibrate
        push_sample(DirBase + 200, 10'd800, 1'b1);              // inside calibration
        push_sample(DirBase + 520, 10'd800, 1'b0);              // becomes stable
        push_sample(DirBase + 700, 10'd800, 1'b0);              // beat
        push_sample(DirBase + 750, 10'd800, 1'b0);              // too soon
        push_sample(DirBase + 1100, 10'd300, 1'b0);             // below threshold
        push_sample(DirBase + 1200, 10'd900, 1'b0);             // beat
        push_sample(DirBase + 4201, 10'd300, 1'b1);             // silence, recalibrate, keeps
        push_sample(DirBase + 4300, 10'd300, 1'b0);             // still calibrating, keeps
        push_sample(DirBase + 4800, 10'd100, 1'b0);             // at low edge, invalid
        push_sample(DirBase + 4850, 10'd1000, 1'b0);            // at high edge, invalid
        push_sample(DirBase + 4900, 10'd999, 1'b0);             // becomes stable
        push_sample(DirBase + 5000, 10'd550, 1'b0);             // equal to threshold
        push_sample(DirBase + 5100, 10'd551, 1'b0);             // beat
        push_sample(DirBase + 5400, 10'd700, 1'b0);             // exactly min interval
        push_sample(DirBase + 5401, 10'd700, 1'b0);             // beat
        push_sample(DirBase + 16901, 10'd50, 1'b1);             // buzzer, odd second
        push_sample(DirBase + 17901, 10'd50, 1'b0);             // buzzer, even second
        push_sample(DirBase + 3000, 10'd50, 1'b1);              // time going backwards
        push_sample(32'hFFFF_FFF0, 10'd600, 1'b1);              // near wrap, recalibrate
        push_sample(32'h0000_0005, 10'd600, 1'b0);              // across the wrap
        push_sample(32'h8000_0000, 10'd1023, 1'b1);
        push_sample(32'h7FFF_FFFF, 10'd1, 1'b0);

        // random phases, each with its own settings and traffic shape
        for (phase = 0; phase < RandomPhases; phase++) begin
            s_valid <= 1'b0;
            wait (readouts_in_flight == 0);
            repeat (DrainCycles) @(negedge aclk);
            write_config(phase_config(phase));
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
            endcase
            stim_time = $urandom();
            beat_anchor = stim_time;
            beat_period = $urandom_range(350, 1100);
            flat_left = 0;
            for (n = 0; n < ItemsPerPhase; n++) begin
                // long readout hold-off while items keep coming
                if (n == ItemsPerPhase / 2 && (phase % 4) < 2) begin
                    long_hold_req = 1'b1;
                end
                next_sample_item();
            end
        end

        s_valid <= 1'b0;
        wait (readouts_in_flight == 0);
        repeat (DrainCycles) @(negedge aclk);
        if (fail_count == 0 && readouts_in_flight == 0) begin
            $display("pulse_detector_with_timeout_alarm_unit_tb: PASS");
        end else begin
            $display("pulse_detector_with_timeout_alarm_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

### files.f
hdl/pdta_pkg.sv
hdl/pdta_cfg.sv
hdl/pulse_detector_with_timeout_alarm_unit.sv
hdl/pdta_checker.sv
bench/pdta_readout_checker.sv
bench/pulse_detector_with_timeout_alarm_unit_tb.sv
